### src/biped_gait_trajectory_sequencer_defines.svh
// ----------------------------------------------------------------------------
// Biped gait trajectory sequencer: assertion macros
// Shared property shorthands, clocked on i_clk and gated by i_rst_n.
// ----------------------------------------------------------------------------
`ifndef BIPED_GAIT_TRAJECTORY_SEQUENCER_DEFINES_SVH
`define BIPED_GAIT_TRAJECTORY_SEQUENCER_DEFINES_SVH

// The consequent must hold in the cycle after the antecedent.
`define BGTS_ASSERT_NEXT(lbl, ant, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ant) |=> (cons)) \
        else $error(msg);

// The expression must hold at every edge out of reset.
`define BGTS_ASSERT_ALWAYS(lbl, expr, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error(msg);

`endif

### src/bgts_pkg.sv
// ----------------------------------------------------------------------------
// Biped gait trajectory sequencer package
// Widths, phase codes, register indexes, command types and the sine table.
// ----------------------------------------------------------------------------
package bgts_pkg;

    localparam int SINE_TABLE_DEPTH = 256;
    localparam int SINE_IDX_W       = $clog2(SINE_TABLE_DEPTH);
    localparam int ANGLE_W          = SINE_IDX_W + 2;
    localparam int POS_W            = 14;
    localparam int TIMER_W          = 16;
    localparam int NUM_W            = TIMER_W + SINE_IDX_W + 4;
    localparam int DEN_W            = TIMER_W + 2;
    localparam int REM_W            = TIMER_W + 3;
    localparam int CNT_W            = $clog2(NUM_W);
    localparam int SIN_W            = 17;
    localparam int MULOP_W          = 18;
    localparam int PROD_W           = 16;
    localparam int WIDE_W           = 17;
    localparam int CFG_DATA_W       = 16;
    localparam int CFG_IDX_W        = 3;
    localparam int ELAPSED_W        = 10;
    localparam int PHASE_W          = 4;
    localparam int BASE_RESET       = 6880;
    localparam logic [63:0] PI_Q30  = 64'd3373259426;

    localparam logic [PHASE_W-1:0] PH_WAIT = 4'd0;
    localparam logic [PHASE_W-1:0] PH_SWAY = 4'd1;
    localparam logic [PHASE_W-1:0] PH_LLIFT = 4'd2;
    localparam logic [PHASE_W-1:0] PH_LFWD = 4'd3;
    localparam logic [PHASE_W-1:0] PH_LDROP = 4'd4;
    localparam logic [PHASE_W-1:0] PH_SHIFT_R = 4'd5;
    localparam logic [PHASE_W-1:0] PH_RLIFT = 4'd6;
    localparam logic [PHASE_W-1:0] PH_RFWD = 4'd7;
    localparam logic [PHASE_W-1:0] PH_RDROP = 4'd8;
    localparam logic [PHASE_W-1:0] PH_SHIFT_L = 4'd9;
    localparam logic [PHASE_W-1:0] PH_LLIFT2 = 4'd10;
    localparam logic [PHASE_W-1:0] PH_LFWD2 = 4'd11;

    localparam logic [CFG_IDX_W-1:0] CFG_BASE_HEIGHT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LIFT_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LATERAL_AMP = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FORWARD_AMP = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIT_PERIOD = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_START_DELAY = 3'd5;

    typedef struct packed {
        logic [12:0] base_height;
        logic [11:0] lift_height;
        logic [11:0] lateral_amplitude;
        logic [11:0] forward_amplitude;
        logic [15:0] gait_period_ms;
        logic [15:0] start_delay_ms;
    } t_cfg;

    typedef struct packed {
        logic       load_k;
        logic       div_step;
        logic       load_h;
        logic       save_trig;
        logic       mul_en;
        logic [1:0] mul_slot;
        logic       update;
    } t_cmd;

    typedef logic [15:0] t_sine_lut [SINE_TABLE_DEPTH];

    // Quarter-wave Q15 sine built by a truncated Taylor series in Q30.
    function automatic t_sine_lut f_build_sine();
        t_sine_lut   lut;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        longint      sum;
        for (int i = 0; i < SINE_TABLE_DEPTH; i++) begin
            x    = (PI_Q30 * 64'(i)) / 64'(2 * SINE_TABLE_DEPTH);
            x2   = (x * x) >> 30;
            term = x;
            sum  = longint'(x);
            for (int n = 1; n <= 8; n++) begin
                term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
                if ((n % 2) == 1) begin
                    sum = sum - longint'(term);
                end else begin
                    sum = sum + longint'(term);
                end
            end
            if (sum < 0) begin
                sum = 0;
            end
            lut[i] = 16'((64'(sum) + 64'd16384) >> 15);
        end
        return lut;
    endfunction

    localparam t_sine_lut SINE_LUT = f_build_sine();

    // Signed Q15 sine of angle index k (full turn = 4 * table depth).
    function automatic logic signed [SIN_W-1:0] f_sine(input logic [ANGLE_W-1:0] k);
        logic [1:0]            quad;
        logic [SINE_IDX_W-1:0] r;
        logic [SIN_W-1:0]      v;
        quad = k[ANGLE_W-1 -: 2];
        r    = k[SINE_IDX_W-1:0];
        if (quad[0]) begin
            if (r == '0) begin
                v = SIN_W'(32768);
            end else begin
                v = SIN_W'(SINE_LUT[SINE_IDX_W'(~r + 1'b1)]);
            end
        end else begin
            v = SIN_W'(SINE_LUT[r]);
        end
        return quad[1] ? -$signed(v) : $signed(v);
    endfunction

endpackage

### src/bgts_in_if.sv
// ----------------------------------------------------------------------------
// Tick input channel
// Valid/ready channel carrying the elapsed time of one tick.
// ----------------------------------------------------------------------------
interface bgts_in_if import bgts_pkg::*;;
    logic                 valid;
    logic                 ready;
    logic [ELAPSED_W-1:0] elapsed_ms;

    modport source (output valid, output elapsed_ms, input ready);
    modport sink (input valid, input elapsed_ms, output ready);
endinterface

### src/bgts_out_if.sv
// ----------------------------------------------------------------------------
// Foot position output channel
// Valid/ready channel carrying six foot coordinates and the gait phase.
// ----------------------------------------------------------------------------
interface bgts_out_if import bgts_pkg::*;;
    logic                      valid;
    logic                      ready;
    logic signed [POS_W-1:0]   right_x;
    logic signed [POS_W-1:0]   right_y;
    logic signed [POS_W-1:0]   right_z;
    logic signed [POS_W-1:0]   left_x;
    logic signed [POS_W-1:0]   left_y;
    logic signed [POS_W-1:0]   left_z;
    logic        [PHASE_W-1:0] gait_phase;

    modport source (output valid, output right_x, output right_y, output right_z,
                    output left_x, output left_y, output left_z, output gait_phase,
                    input ready);
    modport sink (input valid, input right_x, input right_y, input right_z,
                  input left_x, input left_y, input left_z, input gait_phase,
                  output ready);
endinterface

### src/bgts_ctrl.sv
// ----------------------------------------------------------------------------
// Gait sequencer controller
// Steps each tick through two divisions, trig lookup, three products, update.
// ----------------------------------------------------------------------------
module bgts_ctrl import bgts_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  logic i_out_ready,
    output logic o_in_ready,
    output logic o_out_valid,
    output t_cmd o_cmd
);

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_DIVK  = 8'b0000_0010,
        S_LOADH = 8'b0000_0100,
        S_DIVH  = 8'b0000_1000,
        S_TRIG  = 8'b0001_0000,
        S_MUL0  = 8'b0010_0000,
        S_MUL1  = 8'b0100_0000,
        S_MUL2  = 8'b1000_0000
    } t_state;

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_out_valid, n_out_valid;
    logic             upd_fire;
    logic             cnt_last;

    assign cnt_last    = (r_cnt == CNT_W'(NUM_W - 1));
    assign upd_fire    = (r_state == S_MUL2) && (!r_out_valid || i_out_ready);
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd       = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_k = 1'b1;
                    n_cnt        = '0;
                    n_state      = S_DIVK;
                end
            end
            S_DIVK: begin
                o_cmd.div_step = 1'b1;
                n_cnt          = r_cnt + 1'b1;
                if (cnt_last) begin
                    n_state = S_LOADH;
                end
            end
            S_LOADH: begin
                o_cmd.load_h = 1'b1;
                n_cnt        = '0;
                n_state      = S_DIVH;
            end
            S_DIVH: begin
                o_cmd.div_step = 1'b1;
                n_cnt          = r_cnt + 1'b1;
                if (cnt_last) begin
                    n_state = S_TRIG;
                end
            end
            S_TRIG: begin
                o_cmd.save_trig = 1'b1;
                n_state         = S_MUL0;
            end
            S_MUL0: begin
                o_cmd.mul_en   = 1'b1;
                o_cmd.mul_slot = 2'd0;
                n_state        = S_MUL1;
            end
            S_MUL1: begin
                o_cmd.mul_en   = 1'b1;
                o_cmd.mul_slot = 2'd1;
                n_state        = S_MUL2;
            end
            S_MUL2: begin
                // The last product and the state update share this cycle's
                // stall: the coordinate registers are the output payload.
                o_cmd.mul_slot = 2'd2;
                if (upd_fire) begin
                    o_cmd.update = 1'b1;
                    n_out_valid  = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

### src/bgts_dp.sv
// ----------------------------------------------------------------------------
// Gait sequencer datapath
// Angle divider, sine lookup, shared multiplier and the gait state registers.
// ----------------------------------------------------------------------------
module bgts_dp import bgts_pkg::*; (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  t_cmd                        i_cmd,
    input  t_cfg                        i_cfg,
    input  logic [ELAPSED_W-1:0]        i_elapsed_ms,
    output logic signed [POS_W-1:0]     o_right_x,
    output logic signed [POS_W-1:0]     o_right_y,
    output logic signed [POS_W-1:0]     o_right_z,
    output logic signed [POS_W-1:0]     o_left_x,
    output logic signed [POS_W-1:0]     o_left_y,
    output logic signed [POS_W-1:0]     o_left_z,
    output logic [PHASE_W-1:0]          o_gait_phase
);

    function automatic logic signed [POS_W-1:0] f_sat(input logic signed [WIDE_W-1:0] v);
        if (v > WIDE_W'(8191)) begin
            return POS_W'(8191);
        end else if (v < -WIDE_W'(8192)) begin
            return POS_W'(-8192);
        end
        return POS_W'(v);
    endfunction

    logic [ELAPSED_W-1:0]       r_e;
    logic [NUM_W-1:0]           r_num;
    logic [DEN_W-1:0]           r_den;
    logic [REM_W-1:0]           r_rem;
    logic [ANGLE_W-1:0]         r_quo;
    logic [ANGLE_W-1:0]         r_k;
    logic signed [SIN_W-1:0]    r_s, r_c, r_ch;
    logic signed [PROD_W-1:0]   r_prod [2];
    logic signed [POS_W-1:0]    r_rx, r_ry, r_rz, r_lx, r_ly, r_lz;
    logic [PHASE_W-1:0]         r_phase;
    logic [TIMER_W-1:0]         r_timer;

    logic [TIMER_W-1:0]         per;
    logic [REM_W-1:0]           rem_sh;
    logic                       rem_ge;
    logic [11:0]                mul_amp;
    logic signed [MULOP_W-1:0]  mul_sv;
    logic [MULOP_W-1:0]         mul_mag;
    logic [29:0]                mul_m;
    logic [PROD_W-1:0]          mul_r;
    logic signed [PROD_W-1:0]   mul_res;
    logic qend, hend;
    logic signed [WIDE_W-1:0]   bb, hh, ll, ff;
    logic signed [WIDE_W-1:0]   p0, p1, p2;
    logic signed [POS_W-1:0]    n_rx, n_ry, n_rz, n_lx, n_ly, n_lz;
    logic [PHASE_W-1:0]         n_phase;
    logic [TIMER_W-1:0]         t_new;
    logic [TIMER_W:0]           t_sum;

    assign per    = (i_cfg.gait_period_ms == '0) ? TIMER_W'(1) : i_cfg.gait_period_ms;
    assign rem_sh = {r_rem[REM_W-2:0], r_num[NUM_W-1]};
    assign rem_ge = (rem_sh >= REM_W'(r_den));

    // Restoring divider, one quotient bit per cycle; only the angle bits
    // of the quotient are kept since the index wraps at a full turn.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_k) begin
            r_e   <= i_elapsed_ms;
            r_num <= NUM_W'({r_timer, (SINE_IDX_W + 3)'(0)}) + NUM_W'(per);
            r_den <= DEN_W'({per, 1'b0});
            r_rem <= '0;
        end else if (i_cmd.load_h) begin
            r_k   <= r_quo;
            r_num <= NUM_W'({r_timer, (SINE_IDX_W + 3)'(0)}) + NUM_W'({per, 1'b0});
            r_den <= DEN_W'({per, 2'b00});
            r_rem <= '0;
        end else if (i_cmd.div_step) begin
            r_num <= {r_num[NUM_W-2:0], 1'b0};
            r_rem <= rem_ge ? (rem_sh - REM_W'(r_den)) : rem_sh;
            r_quo <= {r_quo[ANGLE_W-2:0], rem_ge};
        end
        if (i_cmd.save_trig) begin
            r_s  <= f_sine(r_k);
            r_c  <= f_sine(r_k + ANGLE_W'(SINE_TABLE_DEPTH));
            r_ch <= f_sine(r_quo + ANGLE_W'(SINE_TABLE_DEPTH));
        end
        // The third product feeds the update directly and is not stored.
        if (i_cmd.mul_en) begin
            r_prod[i_cmd.mul_slot[0]] <= mul_res;
        end
    end

    // Operand choice for the three product slots of each phase.
    always_comb begin
        mul_amp = i_cfg.forward_amplitude;
        mul_sv  = MULOP_W'(r_c);
        case (r_phase)
            PH_SWAY: begin
                mul_amp = i_cfg.lateral_amplitude;
                mul_sv  = MULOP_W'(r_s);
            end
            PH_LLIFT, PH_RLIFT, PH_LLIFT2: begin
                mul_amp = i_cfg.lift_height;
                mul_sv  = MULOP_W'(r_s);
            end
            PH_LFWD: begin
                mul_sv = MULOP_W'(r_s);
            end
            PH_LDROP, PH_RDROP: begin
                mul_amp = i_cfg.lift_height;
            end
            PH_SHIFT_R, PH_SHIFT_L: begin
                case (i_cmd.mul_slot)
                    2'd0:    mul_sv = MULOP_W'(r_ch);
                    2'd1:    mul_sv = MULOP_W'(r_ch) - MULOP_W'(32768);
                    default: mul_amp = i_cfg.lateral_amplitude;
                endcase
            end
            default: ;
        endcase
    end

    // Amplitude times Q15 sine, rounded half away from zero.
    assign mul_mag = mul_sv[MULOP_W-1] ? MULOP_W'(-mul_sv) : MULOP_W'(mul_sv);
    assign mul_m   = 30'(mul_amp) * 30'(mul_mag[SIN_W-1:0]);
    assign mul_r   = PROD_W'((mul_m + 30'd16384) >> 15);
    assign mul_res = mul_sv[MULOP_W-1] ? -$signed(mul_r) : $signed(mul_r);

    assign bb = $signed(WIDE_W'(i_cfg.base_height));
    assign hh = $signed(WIDE_W'(i_cfg.lift_height));
    assign ll = $signed(WIDE_W'(i_cfg.lateral_amplitude));
    assign ff = $signed(WIDE_W'(i_cfg.forward_amplitude));
    assign p0 = WIDE_W'(r_prod[0]);
    assign p1 = WIDE_W'(r_prod[1]);
    assign p2 = WIDE_W'(mul_res);
    assign qend = ({2'b00, r_timer} << 2) > (TIMER_W + 2)'(per);
    assign hend = ({1'b0, r_timer} << 1) > (TIMER_W + 1)'(per);

    always_comb begin
        n_rx    = r_rx;
        n_ry    = r_ry;
        n_rz    = r_rz;
        n_lx    = r_lx;
        n_ly    = r_ly;
        n_lz    = r_lz;
        n_phase = r_phase;
        t_new   = r_timer;
        case (r_phase)
            PH_SWAY: begin
                n_ry = f_sat(-p0);
                n_ly = f_sat(p0);
                if (qend) begin
                    n_ry = f_sat(-ll); n_ly = f_sat(ll); n_phase = PH_LLIFT; t_new = '0;
                end
            end
            PH_LLIFT, PH_LLIFT2: begin
                n_lz = f_sat(bb - p0);
                if (qend) begin
                    n_lz = f_sat(bb - hh); t_new = '0;
                    n_phase = (r_phase == PH_LLIFT) ? PH_LFWD : PH_LFWD2;
                end
            end
            PH_LFWD: begin
                n_lx = f_sat(p0);
                if (qend) begin
                    n_lx = f_sat(ff); n_phase = PH_LDROP; t_new = '0;
                end
            end
            PH_LDROP: begin
                n_lz = f_sat(bb - p0);
                if (qend) begin
                    n_lz = f_sat(bb); n_phase = PH_SHIFT_R; t_new = '0;
                end
            end
            PH_SHIFT_R: begin
                n_lx = f_sat(p0);
                n_rx = f_sat(p1);
                n_ry = f_sat(-p2);
                n_ly = f_sat(p2);
                if (hend) begin
                    n_lx = '0; n_rx = f_sat(-ff); n_ry = f_sat(ll); n_ly = f_sat(-ll);
                    n_phase = PH_RLIFT; t_new = '0;
                end
            end
            PH_RLIFT: begin
                n_rz = f_sat(bb - p0);
                if (qend) begin
                    n_rz = f_sat(bb - hh); n_phase = PH_RFWD; t_new = '0;
                end
            end
            PH_RFWD: begin
                n_rx = f_sat(-p0);
                if (hend) begin
                    n_rx = f_sat(ff); n_phase = PH_RDROP; t_new = '0;
                end
            end
            PH_RDROP: begin
                n_rz = f_sat(bb - p0);
                if (qend) begin
                    n_rz = f_sat(bb); n_phase = PH_SHIFT_L; t_new = '0;
                end
            end
            PH_SHIFT_L: begin
                n_lx = f_sat(p1);
                n_rx = f_sat(p0);
                n_ry = f_sat(p2);
                n_ly = f_sat(-p2);
                if (hend) begin
                    n_lx = f_sat(-ff); n_rx = '0; n_ry = f_sat(-ll); n_ly = f_sat(ll);
                    n_phase = PH_LLIFT2; t_new = '0;
                end
            end
            PH_LFWD2: begin
                n_lx = f_sat(-p0);
                if (hend) begin
                    n_lx = f_sat(ff); n_phase = PH_LDROP; t_new = '0;
                end
            end
            default: begin
                if (r_timer > i_cfg.start_delay_ms) begin
                    n_phase = PH_SWAY; t_new = '0;
                end
            end
        endcase
    end

    assign t_sum = {1'b0, t_new} + (TIMER_W + 1)'(r_e);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rx    <= '0;
            r_ry    <= '0;
            r_lx    <= '0;
            r_ly    <= '0;
            r_rz    <= POS_W'(BASE_RESET);
            r_lz    <= POS_W'(BASE_RESET);
            r_phase <= PH_WAIT;
            r_timer <= '0;
        end else if (i_cmd.update) begin
            r_rx    <= n_rx;
            r_ry    <= n_ry;
            r_rz    <= n_rz;
            r_lx    <= n_lx;
            r_ly    <= n_ly;
            r_lz    <= n_lz;
            r_phase <= n_phase;
            r_timer <= t_sum[TIMER_W] ? '1 : t_sum[TIMER_W-1:0];
        end
    end

    assign o_right_x    = r_rx;
    assign o_right_y    = r_ry;
    assign o_right_z    = r_rz;
    assign o_left_x     = r_lx;
    assign o_left_y     = r_ly;
    assign o_left_z     = r_lz;
    assign o_gait_phase = r_phase;

endmodule

### src/biped_gait_trajectory_sequencer.sv
// Each tick runs two 28-step angle divisions on a shared restoring divider,
//   a reload state, trig lookup and three products with the state update on
//   the last; the result beat is offered once that update is registered.
// A new tick beat is accepted only after the previous one is through, and
//   the final update also waits while the previous result beat is not taken.
// Reset (synchronous, active low): start wait phase, timer zero, x/y zero,
//   heights and settings at their defaults, divider and trig state not reset.
`include "biped_gait_trajectory_sequencer_defines.svh"
// ----------------------------------------------------------------------------
// Biped gait trajectory sequencer
// Per tick, advances a walking gait and emits six foot coordinates.
// ----------------------------------------------------------------------------
module biped_gait_trajectory_sequencer import bgts_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    bgts_in_if.sink               i_in,
    bgts_out_if.source            o_out,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    // Configuration registers. Writes must arrive only while the block is idle;
    // the block does not enforce this. The datapath reads them directly without shadowing.
    t_cfg r_cfg;
    t_cmd cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.base_height       <= 13'd6880;
            r_cfg.lift_height       <= 12'd960;
            r_cfg.lateral_amplitude <= 12'd2240;
            r_cfg.forward_amplitude <= 12'd1440;
            r_cfg.gait_period_ms    <= 16'd2000;
            r_cfg.start_delay_ms    <= 16'd3000;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_BASE_HEIGHT: r_cfg.base_height       <= i_cfg_data[12:0];
                CFG_LIFT_HEIGHT: r_cfg.lift_height       <= i_cfg_data[11:0];
                CFG_LATERAL_AMP: r_cfg.lateral_amplitude <= i_cfg_data[11:0];
                CFG_FORWARD_AMP: r_cfg.forward_amplitude <= i_cfg_data[11:0];
                CFG_GAIT_PERIOD: r_cfg.gait_period_ms    <= i_cfg_data;
                CFG_START_DELAY: r_cfg.start_delay_ms    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // The controller sequences each tick; the datapath holds the gait state,
    // which doubles as the output payload since it only changes on the
    // update cycle, and that cycle waits until the previous beat is taken.
    bgts_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_out_ready (o_out.ready),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .o_cmd       (cmd)
    );

    bgts_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_cfg        (r_cfg),
        .i_elapsed_ms (i_in.elapsed_ms),
        .o_right_x    (o_out.right_x),
        .o_right_y    (o_out.right_y),
        .o_right_z    (o_out.right_z),
        .o_left_x     (o_out.left_x),
        .o_left_y     (o_out.left_y),
        .o_left_z     (o_out.left_z),
        .o_gait_phase (o_out.gait_phase)
    );

    // Once walking starts, the gait never returns to the start wait.
    `BGTS_ASSERT_NEXT(a_no_return_to_wait, o_out.gait_phase != PH_WAIT, o_out.gait_phase != PH_WAIT, "gait fell back to start wait")
    // Phase codes stay within the defined gait.
    `BGTS_ASSERT_ALWAYS(a_phase_range, o_out.gait_phase <= PH_LFWD2, "phase code out of range")
    // An accepted tick keeps the input closed while it is processed.
    `BGTS_ASSERT_NEXT(a_busy_after_accept, i_in.valid && i_in.ready, !i_in.ready, "input reopened during tick")

endmodule

### dv/bgts_gait_checker.sv
// ----------------------------------------------------------------------------
// Gait sequencer checker
// Watches the tick and foot position channels and the register write port.
// It predicts each result beat from a private gait model and compares it.
// ----------------------------------------------------------------------------
module bgts_gait_checker import bgts_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    bgts_in_if                    i_in,
    bgts_out_if                   i_out,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                    o_fail_count,
    output int                    o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int  QDEPTH   = 256;
    localparam int  FULL_TURN = 4 * QDEPTH;
    localparam int  POS_HI   = 8191;
    localparam int  POS_LO   = -8192;
    localparam int  UNIT_Q15 = 32768;

    typedef struct {
        logic signed [POS_W-1:0] right_x;
        logic signed [POS_W-1:0] right_y;
        logic signed [POS_W-1:0] right_z;
        logic signed [POS_W-1:0] left_x;
        logic signed [POS_W-1:0] left_y;
        logic signed [POS_W-1:0] left_z;
        logic [PHASE_W-1:0]      phase;
    } t_foot_pose;

    t_foot_pose   pose_queue[$];
    int           quarter_wave[QDEPTH];

    // Gait state and settings as seen by the model.
    logic [12:0]  base_h;
    logic [11:0]  lift_h;
    logic [11:0]  sway_amp;
    logic [11:0]  stride_amp;
    logic [15:0]  period_ms;
    logic [15:0]  delay_ms;
    logic [3:0]   phase_q;
    logic [15:0]  timer_q;
    longint       rx_q, ry_q, rz_q, lx_q, ly_q, lz_q;

    // Quarter-wave sine in Q15 from a truncated Taylor series in Q30.
    initial begin
        logic [63:0] x, x2, term;
        longint      acc;
        for (int i = 0; i < QDEPTH; i++) begin
            x    = (64'd3373259426 * i) / (2 * QDEPTH);
            x2   = (x * x) >> 30;
            term = x;
            acc  = longint'(x);
            for (int n = 1; n <= 8; n++) begin
                term = ((term * x2) >> 30) / ((2 * n) * (2 * n + 1));
                acc  = (n % 2 == 1) ? acc - longint'(term) : acc + longint'(term);
            end
            if (acc < 0) acc = 0;
            quarter_wave[i] = int'((acc + 16384) >>> 15);
        end
    end

    function automatic longint clamp_pos(longint v);
        return (v > POS_HI) ? POS_HI : ((v < POS_LO) ? POS_LO : v);
    endfunction

    function automatic longint turn_index(longint t, longint per);
        return ((t * FULL_TURN * 2 + per) / (2 * per)) % FULL_TURN;
    endfunction

    function automatic longint sine_q15(longint k);
        longint q, r, v;
        k = k % FULL_TURN;
        q = k / QDEPTH;
        r = k % QDEPTH;
        if (q % 2 == 1) v = (r == 0) ? UNIT_Q15 : quarter_wave[QDEPTH - r];
        else            v = quarter_wave[r];
        return (q >= 2) ? -v : v;
    endfunction

    // Amplitude times Q15 sine, rounded half away from zero.
    function automatic longint amp_times(longint amp, longint s);
        longint p, m, r;
        p = amp * s;
        m = (p < 0) ? -p : p;
        r = (m + 16384) >>> 15;
        return (p < 0) ? -r : r;
    endfunction

    // Advance the gait by one tick and queue the pose it shows.
    task automatic advance_gait(input logic [ELAPSED_W-1:0] elapsed);
        longint     per, t, s, c, ch, bh, lh, la, fa, nt, sum;
        logic [3:0] p;
        bit         qend, hend;
        t_foot_pose pose;
        per  = (period_ms == 0) ? 1 : period_ms;
        t    = timer_q;
        qend = 4 * t > per;
        hend = 2 * t > per;
        s    = sine_q15(turn_index(t, per));
        c    = sine_q15(turn_index(t, per) + QDEPTH);
        ch   = sine_q15(turn_index(t, 2 * per) + QDEPTH);
        bh = base_h; lh = lift_h; la = sway_amp; fa = stride_amp;
        nt = t;
        p  = phase_q;
        case (p)
            PH_SWAY: begin
                ry_q = clamp_pos(-amp_times(la, s));
                ly_q = clamp_pos(amp_times(la, s));
                if (qend) begin
                    nt = 0; ry_q = clamp_pos(-la); ly_q = clamp_pos(la); p = PH_LLIFT;
                end
            end
            PH_LLIFT: begin
                lz_q = clamp_pos(bh - amp_times(lh, s));
                if (qend) begin
                    nt = 0; lz_q = clamp_pos(bh - lh); p = PH_LFWD;
                end
            end
            PH_LFWD: begin
                lx_q = clamp_pos(amp_times(fa, s));
                if (qend) begin
                    nt = 0; lx_q = clamp_pos(fa); p = PH_LDROP;
                end
            end
            PH_LDROP: begin
                lz_q = clamp_pos(bh - amp_times(lh, c));
                if (qend) begin
                    nt = 0; lz_q = clamp_pos(bh); p = PH_SHIFT_R;
                end
            end
            PH_SHIFT_R: begin
                lx_q = clamp_pos(amp_times(fa, ch));
                rx_q = clamp_pos(amp_times(fa, ch - UNIT_Q15));
                ry_q = clamp_pos(-amp_times(la, c));
                ly_q = clamp_pos(amp_times(la, c));
                if (hend) begin
                    nt = 0; lx_q = 0; rx_q = clamp_pos(-fa);
                    ry_q = clamp_pos(la); ly_q = clamp_pos(-la); p = PH_RLIFT;
                end
            end
            PH_RLIFT: begin
                rz_q = clamp_pos(bh - amp_times(lh, s));
                if (qend) begin
                    nt = 0; rz_q = clamp_pos(bh - lh); p = PH_RFWD;
                end
            end
            PH_RFWD: begin
                rx_q = clamp_pos(-amp_times(fa, c));
                if (hend) begin
                    nt = 0; rx_q = clamp_pos(fa); p = PH_RDROP;
                end
            end
            PH_RDROP: begin
                rz_q = clamp_pos(bh - amp_times(lh, c));
                if (qend) begin
                    nt = 0; rz_q = clamp_pos(bh); p = PH_SHIFT_L;
                end
            end
            PH_SHIFT_L: begin
                lx_q = clamp_pos(amp_times(fa, ch - UNIT_Q15));
                rx_q = clamp_pos(amp_times(fa, ch));
                ry_q = clamp_pos(amp_times(la, c));
                ly_q = clamp_pos(-amp_times(la, c));
                if (hend) begin
                    nt = 0; lx_q = clamp_pos(-fa); rx_q = 0;
                    ry_q = clamp_pos(-la); ly_q = clamp_pos(la); p = PH_LLIFT2;
                end
            end
            PH_LLIFT2: begin
                lz_q = clamp_pos(bh - amp_times(lh, s));
                if (qend) begin
                    nt = 0; lz_q = clamp_pos(bh - lh); p = PH_LFWD2;
                end
            end
            PH_LFWD2: begin
                lx_q = clamp_pos(-amp_times(fa, c));
                if (hend) begin
                    nt = 0; lx_q = clamp_pos(fa); p = PH_LDROP;
                end
            end
            default: begin
                if (t > delay_ms) begin
                    nt = 0; p = PH_SWAY;
                end
            end
        endcase
        phase_q = p;
        sum     = nt + elapsed;
        timer_q = (sum > 65535) ? 16'hFFFF : 16'(sum);
        pose.right_x = POS_W'(rx_q);
        pose.right_y = POS_W'(ry_q);
        pose.right_z = POS_W'(rz_q);
        pose.left_x  = POS_W'(lx_q);
        pose.left_y  = POS_W'(ly_q);
        pose.left_z  = POS_W'(lz_q);
        pose.phase   = phase_q;
        pose_queue.push_back(pose);
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            o_fail_count++;
        end
    endtask

    initial o_fail_count = 0;

    always @(posedge i_clk) begin
        t_foot_pose want;
        if (!i_rst_n) begin
            base_h = 13'd6880; lift_h = 12'd960; sway_amp = 12'd2240;
            stride_amp = 12'd1440; period_ms = 16'd2000; delay_ms = 16'd3000;
            phase_q = PH_WAIT; timer_q = '0;
            rx_q = 0; ry_q = 0; lx_q = 0; ly_q = 0; rz_q = 6880; lz_q = 6880;
            pose_queue.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_BASE_HEIGHT: base_h     = i_cfg_data[12:0];
                    CFG_LIFT_HEIGHT: lift_h     = i_cfg_data[11:0];
                    CFG_LATERAL_AMP: sway_amp   = i_cfg_data[11:0];
                    CFG_FORWARD_AMP: stride_amp = i_cfg_data[11:0];
                    CFG_GAIT_PERIOD: period_ms  = i_cfg_data;
                    CFG_START_DELAY: delay_ms   = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_out.valid && i_out.ready) begin
                if (pose_queue.size() == 0) begin
                    $error("Result beat arrived with no tick outstanding");
                    o_fail_count++;
                end else begin
                    want = pose_queue.pop_front();
                    check_field("right_x", want.right_x, i_out.right_x);
                    check_field("right_y", want.right_y, i_out.right_y);
                    check_field("right_z", want.right_z, i_out.right_z);
                    check_field("left_x", want.left_x, i_out.left_x);
                    check_field("left_y", want.left_y, i_out.left_y);
                    check_field("left_z", want.left_z, i_out.left_z);
                    check_field("gait_phase", want.phase, i_out.gait_phase);
                end
            end
            if (i_in.valid && i_in.ready) advance_gait(i_in.elapsed_ms);
        end
        o_pending <= pose_queue.size();
    end
endmodule

### dv/tb_biped_gait_trajectory_sequencer.sv
// ----------------------------------------------------------------------------
// Gait sequencer testbench
// Drives timed ticks and register settings into the sequencer, stalls both
// channels at random and reports the checker's verdict at the end.
// ----------------------------------------------------------------------------
module tb_biped_gait_trajectory_sequencer;
    import bgts_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    // A quiet stretch longer than the processing of one tick plus the
    // longest random stall means the block has hung.
    localparam int STALL_LIMIT  = 5000;
    localparam int SETTLE_WAIT  = 100;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    int                    fail_count;
    int                    pending_poses;
    int                    tick_idle_pct = 0;
    int                    pose_stall_pct = 0;
    int                    quiet_cycles = 0;

    bgts_in_if  tick_ch ();
    bgts_out_if pose_ch ();

    initial begin
        tick_ch.valid      = 1'b0;
        tick_ch.elapsed_ms = '0;
        pose_ch.ready      = 1'b0;
    end

    always #10 i_clk = ~i_clk;

    biped_gait_trajectory_sequencer uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (tick_ch),
        .o_out      (pose_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    bgts_gait_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (tick_ch),
        .i_out        (pose_ch),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending_poses)
    );

    // The receiver drops ready on a random share of cycles.
    always @(posedge i_clk) begin
        pose_ch.ready <= ($urandom_range(99) >= pose_stall_pct);
    end

    // Watchdog: any beat on either channel or a register write counts as
    // progress; a long quiet stretch means the block is stuck.
    always @(posedge i_clk) begin
        if ((tick_ch.valid && tick_ch.ready) || (pose_ch.valid && pose_ch.ready) ||
            i_cfg_we || !i_rst_n) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Send one tick beat. The valid stays high between back-to-back beats,
    // and is lowered only when a random gap is inserted before this beat.
    task automatic send_tick(input logic [ELAPSED_W-1:0] elapsed);
        if ($urandom_range(99) < tick_idle_pct) begin
            tick_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        tick_ch.valid      <= 1'b1;
        tick_ch.elapsed_ms <= elapsed;
        do @(posedge i_clk); while (!tick_ch.ready);
    endtask

    // Hold off the sender until every queued pose has come back, then let the
    // block finish its tail work so that settings can be changed safely.
    task automatic drain_poses();
        tick_ch.valid <= 1'b0;
        do @(posedge i_clk); while (pending_poses != 0);
        repeat (SETTLE_WAIT) @(posedge i_clk);
    endtask

    // Write one full set of gait settings plus a write to an unused index,
    // which the block must ignore.
    task automatic load_settings(input int bh, input int lh, input int la,
                                 input int fa, input int per, input int dly);
        int vals[6];
        vals = '{bh, lh, la, fa, per, dly};
        for (int i = 0; i < 6; i++) begin
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= CFG_IDX_W'(i);
            i_cfg_data <= CFG_DATA_W'(vals[i]);
            @(posedge i_clk);
        end
        i_cfg_idx  <= CFG_IDX_W'($urandom_range(6, 7));
        i_cfg_data <= CFG_DATA_W'($urandom);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // Mostly moderate steps so that each phase spans several ticks, with some
    // short and some full-range steps mixed in; long_steps makes most steps large.
    function automatic logic [ELAPSED_W-1:0] pick_elapsed(input bit long_steps);
        int r;
        r = $urandom_range(99);
        if (long_steps && r < 70) return ELAPSED_W'($urandom_range(700, 1023));
        if (r < 30) return ELAPSED_W'($urandom_range(0, 63));
        if (r < 80) return ELAPSED_W'($urandom_range(0, 400));
        return ELAPSED_W'($urandom);
    endfunction

    task automatic run_ticks(input int count, input bit long_steps);
        for (int i = 0; i < count; i++) send_tick(pick_elapsed(long_steps));
    endtask

    initial begin
        logic [ELAPSED_W-1:0] directed[$];
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part with the reset settings: zero and full-scale steps,
        // every single bit, then large steps that walk through the start
        // wait and on through the gait as far as the right drop.
        directed = '{10'd0, 10'd1023, 10'd0, 10'd1, 10'd2, 10'd4, 10'd8, 10'd16,
                     10'd32, 10'd64, 10'd128, 10'd256, 10'd512, 10'd1023,
                     10'd1023, 10'd501, 10'd500, 10'd499, 10'd600, 10'd1000,
                     10'd400, 10'd1023, 10'd700, 10'd900, 10'd1023};
        pose_stall_pct = 0;
        foreach (directed[i]) send_tick(directed[i]);
        drain_poses();

        // Sender idles 16 percent, receiver stalls 47 percent.
        tick_idle_pct  = 16;
        pose_stall_pct = 47;
        // Largest heights and amplitudes, short period, no start wait.
        load_settings(8191, 4095, 4095, 4095, 600, 0);
        run_ticks(100, 1'b0);
        drain_poses();
        // Zero base and lateral amplitude, the shortest period.
        load_settings(0, 4095, 0, 4095, 1, 0);
        run_ticks(60, 1'b0);
        drain_poses();

        // Now the sender is the slower side.
        tick_idle_pct  = 47;
        pose_stall_pct = 16;
        // A zero period behaves like the shortest one.
        load_settings(3000, 2000, 1000, 3000, 0, 5);
        run_ticks(60, 1'b0);
        drain_poses();
        // Longest period and start wait: the gait left the start wait earlier and keeps walking.
        load_settings(8191, 0, 4095, 0, 65535, 65535);
        run_ticks(80, 1'b1);
        drain_poses();

        // No idling from here on.
        tick_idle_pct  = 0;
        pose_stall_pct = 0;
        load_settings($urandom_range(8191), $urandom_range(4095), $urandom_range(4095),
                      $urandom_range(4095), $urandom_range(200, 3000), $urandom_range(2000));
        run_ticks(100, 1'b0);
        drain_poses();
        load_settings(6880, 960, 2240, 1440, 2000, 3000);
        run_ticks(175, 1'b0);

        tick_ch.valid <= 1'b0;
        do @(posedge i_clk); while (pending_poses != 0);
        repeat (SETTLE_WAIT) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule
